[hw/rtl/ptmap_pkg.sv]
// Shared types, constants and helpers of the page table mapper.
`timescale 1ns / 1ps
package ptmap_pkg;

  localparam int NumTableFramesDef = 64;
  localparam int EntriesPerTable   = 512;
  localparam int IdxW              = 9;
  localparam int VpnW              = 36;
  localparam int PpnW              = 40;
  localparam int AddrW             = 52;
  localparam int EntryW            = 64;
  localparam int FrameNumW         = 40;
  localparam int ModChunkW         = 10;
  localparam int ModChunks         = 4;
  localparam int ModCntW           = 2;

  localparam logic [1:0] LvlLeaf = 2'd3;
  localparam logic [1:0] LvlLast = 2'd2;
  localparam logic [11:0] EntryFlags = 12'h003;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_RANGE,
    ST_MOD,
    ST_MRED,
    ST_MTAKE,
    ST_CHECK,
    ST_ALLOC,
    ST_LEAF,
    ST_FAIL
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic rd;
    logic eval;
    logic take_diff;
    logic mod_init;
    logic mod_step;
    logic mod_red;
    logic mod_take;
    logic chk;
    logic alloc_wr;
    logic leaf_wr;
    logic fail;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic entry_zero;
    logic lvl_last;
    logic walk_done;
    logic in_range;
    logic mod_last;
    logic no_room;
    logic out_free;
  } sts_t;

  function automatic logic [IdxW-1:0] level_index(logic [VpnW-1:0] vpn, logic [1:0] lvl);
    logic [IdxW-1:0] r;
    unique case (lvl)
      2'd0:    r = vpn[35:27];
      2'd1:    r = vpn[26:18];
      2'd2:    r = vpn[17:9];
      default: r = vpn[8:0];
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/ptmap_ctrl.sv]
// Sequencer of the page table mapper: clear pass, walk, allocation, and leaf write or out-of-frames result.
`timescale 1ns / 1ps
module ptmap_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ptmap_pkg::sts_t   sts_i,
  output ptmap_pkg::cmd_t   cmd_o
);

  ptmap_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptmap_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ptmap_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = ptmap_pkg::ST_IDLE;
      end
      ptmap_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ptmap_pkg::ST_READ;
        end
      end
      ptmap_pkg::ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ptmap_pkg::ST_WAIT;
      end
      ptmap_pkg::ST_WAIT: begin
        if (sts_i.entry_zero) begin
          state_d = ptmap_pkg::ST_CHECK;
        end else begin
          cmd_o.eval = 1'b1;
          state_d    = ptmap_pkg::ST_RANGE;
        end
      end
      ptmap_pkg::ST_RANGE: begin
        if (sts_i.in_range) begin
          cmd_o.take_diff = 1'b1;
          state_d = sts_i.lvl_last ? ptmap_pkg::ST_CHECK : ptmap_pkg::ST_READ;
        end else begin
          cmd_o.mod_init = 1'b1;
          state_d        = ptmap_pkg::ST_MOD;
        end
      end
      ptmap_pkg::ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        state_d        = ptmap_pkg::ST_MRED;
      end
      ptmap_pkg::ST_MRED: begin
        cmd_o.mod_red = 1'b1;
        state_d = sts_i.mod_last ? ptmap_pkg::ST_MTAKE : ptmap_pkg::ST_MOD;
      end
      ptmap_pkg::ST_MTAKE: begin
        cmd_o.mod_take = 1'b1;
        state_d = sts_i.lvl_last ? ptmap_pkg::ST_CHECK : ptmap_pkg::ST_READ;
      end
      ptmap_pkg::ST_CHECK: begin
        cmd_o.chk = 1'b1;
        if (sts_i.no_room)        state_d = ptmap_pkg::ST_FAIL;
        else if (sts_i.walk_done) state_d = ptmap_pkg::ST_LEAF;
        else                      state_d = ptmap_pkg::ST_ALLOC;
      end
      ptmap_pkg::ST_ALLOC: begin
        cmd_o.alloc_wr = 1'b1;
        if (sts_i.lvl_last) state_d = ptmap_pkg::ST_LEAF;
      end
      ptmap_pkg::ST_LEAF: begin
        if (sts_i.out_free) begin
          cmd_o.leaf_wr = 1'b1;
          state_d       = ptmap_pkg::ST_IDLE;
        end
      end
      ptmap_pkg::ST_FAIL: begin
        if (sts_i.out_free) begin
          cmd_o.fail = 1'b1;
          state_d    = ptmap_pkg::ST_IDLE;
        end
      end
      default: state_d = ptmap_pkg::ST_CLEAR;
    endcase
  end

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ptmap_pkg::ST_CLEAR |-> !in_ready_o)
    else $error("input taken during clear pass");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.clr_wr, cmd_o.alloc_wr, cmd_o.leaf_wr}) <= 1)
    else $error("two table writes in one cycle");

  a_leaf_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.leaf_wr || cmd_o.fail |=> state_q == ptmap_pkg::ST_IDLE)
    else $error("result issued without return to idle");

endmodule

[hw/rtl/ptmap_dp.sv]
// Datapath of the page table mapper: table memory, walk registers, frame modulo, result.
`timescale 1ns / 1ps
module ptmap_dp #(
  parameter int NumFrames = ptmap_pkg::NumTableFramesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ptmap_pkg::cmd_t                 cmd_i,
  output ptmap_pkg::sts_t                 sts_o,
  input  logic                            cfg_valid_i,
  input  logic [ptmap_pkg::AddrW-1:0]     cfg_data_i,
  input  logic [ptmap_pkg::VpnW-1:0]      virt_page_number_i,
  input  logic [ptmap_pkg::PpnW-1:0]      phys_page_number_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            status_o,
  output logic [1:0]                      tables_added_o,
  output logic [ptmap_pkg::EntryW-1:0]    leaf_entry_o
);

  localparam int FiW   = $clog2(NumFrames);
  localparam int CntW  = $clog2(NumFrames + 1);
  localparam int MemAW = FiW + ptmap_pkg::IdxW;
  localparam int Depth = NumFrames * ptmap_pkg::EntriesPerTable;
  localparam int VW    = FiW + ptmap_pkg::ModChunkW;
  localparam int RecSh = VW + FiW;
  localparam int RecKW = VW + 1;
  localparam int PrdW  = VW + RecKW;
  localparam logic [63:0] RecK64 =
    ((64'd1 << RecSh) + 64'(NumFrames) - 64'd1) / 64'(NumFrames);
  localparam logic [RecKW-1:0] RecK = RecKW'(RecK64);
  localparam logic [VW-1:0] NfV = VW'(NumFrames);
  localparam logic [MemAW-1:0] ClrLast = MemAW'(Depth - 1);
  localparam logic [ptmap_pkg::FrameNumW-1:0] NfFn = ptmap_pkg::FrameNumW'(NumFrames);
  localparam logic [CntW:0] NfCnt = (CntW + 1)'(NumFrames);
  localparam logic [FiW:0]  NfRem = (FiW + 1)'(NumFrames);
  localparam logic [ptmap_pkg::ModCntW-1:0] ModLast =
    ptmap_pkg::ModCntW'(ptmap_pkg::ModChunks - 1);

  logic [ptmap_pkg::EntryW-1:0]    mem_q [Depth];
  logic [ptmap_pkg::EntryW-1:0]    rd_q;
  logic [MemAW-1:0]                clr_q;
  logic [ptmap_pkg::AddrW-1:0]     base_q;
  logic [ptmap_pkg::VpnW-1:0]      vpn_q;
  logic [ptmap_pkg::PpnW-1:0]      ppn_q;
  logic [1:0]                      lvl_q;
  logic [FiW-1:0]                  frame_q [4];
  logic [CntW-1:0]                 nf_q;
  logic [ptmap_pkg::FrameNumW-1:0] diff_q;
  logic [ptmap_pkg::FrameNumW-1:0] div_q;
  logic [FiW-1:0]                  rem_q;
  logic [ptmap_pkg::ModChunkW-1:0] quo_q;
  logic [ptmap_pkg::ModCntW-1:0]   mcnt_q;
  logic [1:0]                      added_q;
  logic                            out_valid_q;
  logic                            status_q;
  logic [1:0]                      added_out_q;
  logic [ptmap_pkg::EntryW-1:0]    leaf_q;

  logic [MemAW-1:0]             slot;
  logic [MemAW-1:0]             wr_addr;
  logic [ptmap_pkg::EntryW-1:0] wr_data;
  logic                         wr_en;
  logic [1:0]                   need;
  logic [VW-1:0]                mod_v;
  logic [PrdW-1:0]              mod_prod;
  logic [VW-1:0]                mod_qn;
  logic [VW-1:0]                mod_r;
  logic [ptmap_pkg::EntryW-1:0] leaf_val;
  logic [ptmap_pkg::EntryW-1:0] dir_val;
  logic [1:0]                   lvl_nx;

  assign slot     = {frame_q[lvl_q], ptmap_pkg::level_index(vpn_q, lvl_q)};
  assign need     = ptmap_pkg::LvlLeaf - lvl_q;
  assign lvl_nx   = lvl_q + 2'd1;
  assign leaf_val = {12'd0, ppn_q, ptmap_pkg::EntryFlags};
  assign dir_val  = {12'd0, base_q[51:12] + ptmap_pkg::FrameNumW'(nf_q), ptmap_pkg::EntryFlags};
  assign mod_v    = {rem_q, div_q[ptmap_pkg::FrameNumW-1 -: ptmap_pkg::ModChunkW]};
  assign mod_prod = PrdW'(mod_v) * PrdW'(RecK);
  assign mod_qn   = VW'(quo_q) * NfV;
  assign mod_r    = mod_v - mod_qn;

  always_comb begin
    wr_en   = cmd_i.clr_wr | cmd_i.alloc_wr | cmd_i.leaf_wr;
    wr_addr = cmd_i.clr_wr ? clr_q : slot;
    wr_data = cmd_i.alloc_wr ? dir_val : (cmd_i.leaf_wr ? leaf_val : '0);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (cmd_i.rd) rd_q <= mem_q[slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      base_q      <= '0;
      nf_q        <= CntW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + MemAW'(1);
      if (cfg_valid_i) base_q <= cfg_data_i;
      if (cmd_i.alloc_wr) nf_q <= nf_q + CntW'(1);
      if (cmd_i.leaf_wr || cmd_i.fail) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vpn_q      <= virt_page_number_i;
      ppn_q      <= phys_page_number_i;
      lvl_q      <= 2'd0;
      frame_q[0] <= '0;
    end
    if (cmd_i.eval) diff_q <= rd_q[51:12] - base_q[51:12];
    if (cmd_i.take_diff) begin
      frame_q[lvl_nx] <= diff_q[FiW-1:0];
      lvl_q           <= lvl_nx;
    end
    if (cmd_i.mod_init) begin
      div_q  <= diff_q;
      rem_q  <= '0;
      mcnt_q <= '0;
    end
    if (cmd_i.mod_step) quo_q <= mod_prod[RecSh +: ptmap_pkg::ModChunkW];
    if (cmd_i.mod_red) begin
      div_q  <= {div_q[ptmap_pkg::FrameNumW-ptmap_pkg::ModChunkW-1:0],
                 {ptmap_pkg::ModChunkW{1'b0}}};
      rem_q  <= mod_r[FiW-1:0];
      mcnt_q <= mcnt_q + ptmap_pkg::ModCntW'(1);
    end
    if (cmd_i.mod_take) begin
      frame_q[lvl_nx] <= rem_q;
      lvl_q           <= lvl_nx;
    end
    if (cmd_i.chk) added_q <= need;
    if (cmd_i.alloc_wr) begin
      frame_q[lvl_nx] <= nf_q[FiW-1:0];
      lvl_q           <= lvl_nx;
    end
    if (cmd_i.leaf_wr) begin
      status_q    <= 1'b0;
      added_out_q <= added_q;
      leaf_q      <= leaf_val;
    end
    if (cmd_i.fail) begin
      status_q    <= 1'b1;
      added_out_q <= 2'd0;
      leaf_q      <= '0;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.clr_last   = clr_q == ClrLast;
    sts_o.entry_zero = rd_q == '0;
    sts_o.lvl_last   = lvl_q == ptmap_pkg::LvlLast;
    sts_o.walk_done  = lvl_q == ptmap_pkg::LvlLeaf;
    sts_o.in_range   = diff_q < NfFn;
    sts_o.mod_last   = mcnt_q == ModLast;
    sts_o.no_room    = ({1'b0, nf_q} + (CntW + 1)'(need)) > NfCnt;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign tables_added_o = added_out_q;
  assign leaf_entry_o   = leaf_q;

  a_nf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, nf_q} <= NfCnt)
    else $error("frame allocator past end of table memory");

  a_alloc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_wr |-> !sts_o.no_room)
    else $error("frame taken without room");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mod_take |-> {1'b0, rem_q} < NfRem)
    else $error("frame remainder out of range");

endmodule

[hw/rtl/four_level_page_table_mapper_top.sv]
// Top level of the four-level page table mapper.
`timescale 1ns / 1ps
// Installs one virtual-to-physical page mapping per input word in a four-level table held in
// on-chip memory of NUM_TABLE_FRAMES frames of 512 entries; frame zero is the root. After
// reset the block clears the whole table memory, one entry a cycle, before it takes the
// first input word (base writes are taken throughout). A mapping then takes the word, reads
// each table (read, registered data), turns a present entry into a frame, where that entry
// points outside table memory by a chunked reciprocal modulo, checks for room, writes each
// new table frame and then the leaf, all through the single port of the table memory. Out
// of frames gives status 1 and changes nothing. The result waits in an output register, so
// the next word can be taken while it is still pending.
module four_level_page_table_mapper_top #(
  parameter int NUM_TABLE_FRAMES = ptmap_pkg::NumTableFramesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ptmap_pkg::VpnW-1:0]   virt_page_number_i,
  input  logic [ptmap_pkg::PpnW-1:0]   phys_page_number_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         status_o,
  output logic [1:0]                   tables_added_o,
  output logic [ptmap_pkg::EntryW-1:0] leaf_entry_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ptmap_pkg::AddrW-1:0]  cfg_data_i
);

  ptmap_pkg::cmd_t cmd;
  ptmap_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  ptmap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptmap_dp #(
    .NumFrames (NUM_TABLE_FRAMES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_data_i         (cfg_data_i),
    .virt_page_number_i (virt_page_number_i),
    .phys_page_number_i (phys_page_number_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .tables_added_o     (tables_added_o),
    .leaf_entry_o       (leaf_entry_o)
  );

endmodule

[sim/tb_top.sv]
// Self-checking testbench of the four-level page table mapper.
`timescale 1ns / 1ps
module tb_top;

  localparam int NumFrames = ptmap_pkg::NumTableFramesDef;

  typedef struct {
    logic                        status;
    logic [1:0]                  added;
    logic [ptmap_pkg::EntryW-1:0] leaf;
  } map_result_t;

  typedef struct {
    logic [ptmap_pkg::VpnW-1:0] vpn;
    logic [ptmap_pkg::PpnW-1:0] ppn;
    logic                       typed;
    map_result_t                res;
  } map_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ptmap_pkg::VpnW-1:0] vpn_in = '0;
  logic [ptmap_pkg::PpnW-1:0] ppn_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic status;
  logic [1:0] tables_added;
  logic [ptmap_pkg::EntryW-1:0] leaf_entry;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ptmap_pkg::AddrW-1:0] cfg_data = '0;

  logic [ptmap_pkg::EntryW-1:0] table_mem [int];
  int unsigned free_frame;
  logic [ptmap_pkg::AddrW-1:0] base_reg;
  map_result_t pending_maps [$];
  logic [ptmap_pkg::VpnW-1:0] mapped_vpns [$];
  int errors = 0;
  bit no_stall = 1'b0;

  always #6 clk = ~clk;

  four_level_page_table_mapper_top DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .virt_page_number_i(vpn_in), .phys_page_number_i(ppn_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .tables_added_o(tables_added), .leaf_entry_o(leaf_entry),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  function automatic logic [ptmap_pkg::EntryW-1:0] read_slot(int unsigned frame,
                                                            logic [ptmap_pkg::IdxW-1:0] idx);
    int key;
    key = frame * ptmap_pkg::EntriesPerTable + idx;
    return table_mem.exists(key) ? table_mem[key] : '0;
  endfunction

  function automatic map_result_t map_page(logic [ptmap_pkg::VpnW-1:0] vpn,
                                           logic [ptmap_pkg::PpnW-1:0] ppn);
    map_result_t r;
    logic [ptmap_pkg::IdxW-1:0] idx [4];
    int unsigned frame [4];
    int unsigned need;
    int unsigned first_new;
    logic [ptmap_pkg::EntryW-1:0] e;
    logic [ptmap_pkg::FrameNumW-1:0] fnum;
    logic [ptmap_pkg::AddrW-1:0] addr;
    need = 0;
    first_new = 3;
    idx[0] = vpn[35:27];
    idx[1] = vpn[26:18];
    idx[2] = vpn[17:9];
    idx[3] = vpn[8:0];
    frame[0] = 0;
    for (int l = 0; l < 3; l++) begin
      e = read_slot(frame[l], idx[l]);
      if (e == '0) begin
        need = 3 - l;
        first_new = l;
        break;
      end
      fnum = e[51:12] - base_reg[51:12];
      frame[l+1] = 32'(fnum % NumFrames);
    end
    if (free_frame + need > NumFrames) begin
      r.status = 1'b1;
      r.added = '0;
      r.leaf = '0;
      return r;
    end
    for (int l = first_new; l < 3; l++) begin
      addr = {base_reg[51:12], 12'b0} + (ptmap_pkg::AddrW'(free_frame) << 12);
      table_mem[frame[l] * ptmap_pkg::EntriesPerTable + idx[l]] =
        {12'b0, addr} | ptmap_pkg::EntryW'(ptmap_pkg::EntryFlags);
      frame[l+1] = free_frame;
      free_frame++;
    end
    r.status = 1'b0;
    r.added = need[1:0];
    r.leaf = {12'b0, ppn, 12'b0} | ptmap_pkg::EntryW'(ptmap_pkg::EntryFlags);
    table_mem[frame[3] * ptmap_pkg::EntriesPerTable + idx[3]] = r.leaf;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_stall) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what, logic [ptmap_pkg::EntryW-1:0] got,
                                 logic [ptmap_pkg::EntryW-1:0] exp);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  task automatic send_map(logic [ptmap_pkg::VpnW-1:0] vpn, logic [ptmap_pkg::PpnW-1:0] ppn,
                          bit typed, map_result_t typed_res);
    map_result_t r;
    int gap;
    in_valid <= 1'b1;
    vpn_in <= vpn;
    ppn_in <= ppn;
    do @(posedge clk); while (!in_ready);
    r = map_page(vpn, ppn);
    if (typed) r = typed_res;
    pending_maps.push_back(r);
    if (r.status == 1'b0) mapped_vpns.push_back(vpn);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_base(logic [ptmap_pkg::AddrW-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    base_reg = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random();
    logic [ptmap_pkg::VpnW-1:0] vpn;
    logic [ptmap_pkg::PpnW-1:0] ppn;
    map_result_t none;
    int r;
    none = '{1'b0, 2'b0, '0};
    r = $urandom_range(0, 99);
    vpn = ptmap_pkg::VpnW'({$urandom, $urandom});
    ppn = ptmap_pkg::PpnW'({$urandom, $urandom});
    if (mapped_vpns.size() != 0 && r < 80) begin
      vpn = mapped_vpns[$urandom_range(0, mapped_vpns.size() - 1)];
      if (r < 45) vpn[8:0] = 9'($urandom);
      else if (r < 60) vpn[17:0] = 18'($urandom);
      else if (r < 70) vpn[26:0] = 27'($urandom);
    end
    send_map(vpn, ppn, 1'b0, none);
  endtask

  always @(posedge clk) begin
    map_result_t exp_r;
    if (out_valid && out_ready) begin
      if (pending_maps.size() == 0) begin
        report_mismatch("unexpected result word", leaf_entry, '0);
      end else begin
        exp_r = pending_maps.pop_front();
        if (status !== exp_r.status)
          report_mismatch("status", ptmap_pkg::EntryW'(status),
                          ptmap_pkg::EntryW'(exp_r.status));
        if (tables_added !== exp_r.added)
          report_mismatch("tables_added", ptmap_pkg::EntryW'(tables_added),
                          ptmap_pkg::EntryW'(exp_r.added));
        if (leaf_entry !== exp_r.leaf) report_mismatch("leaf_entry", leaf_entry, exp_r.leaf);
      end
    end
  end

  initial begin
    int hold;
    forever begin
      hold = $urandom_range(1, 20);
      out_ready <= 1'b1;
      repeat (hold) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin
    map_row_t rows [8];
    map_result_t none;
    none = '{1'b0, 2'b0, '0};
    rows[0] = '{36'h0, 40'h0, 1'b1, '{1'b0, 2'd3, 64'h3}};
    rows[1] = '{36'h0, 40'hFF_FFFF_FFFF, 1'b1, '{1'b0, 2'd0, 64'hF_FFFF_FFFF_F003}};
    rows[2] = '{36'hF_FFFF_FFFF, 40'h1, 1'b1, '{1'b0, 2'd3, 64'h1003}};
    rows[3] = '{36'hF_FFFF_FE00, 40'hAA_AAAA_AAAA, 1'b0, none};
    rows[4] = '{36'hF_FFFC_0000, 40'h55_5555_5555, 1'b0, none};
    rows[5] = '{36'h0_0000_01FF, 40'h12_3456_789A, 1'b0, none};
    rows[6] = '{36'h0_0004_0000, 40'h0, 1'b0, none};
    rows[7] = '{36'hA_AAAA_AAAA, 40'h1, 1'b0, none};
    free_frame = 1;
    base_reg = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_map(rows[i].vpn, rows[i].ppn, rows[i].typed, rows[i].res);
    write_base(52'h0_0123_4567_8000);
    // walk fresh top-level slots until the frame pool runs dry
    for (int i = 2; i < 24; i++) send_map({9'(i), 27'h155_5555}, 40'(i), 1'b0, none);
    write_base(52'hF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 400; i++) send_random();
    no_stall = 1'b1;
    for (int i = 0; i < 150; i++) send_random();
    no_stall = 1'b0;
    drain();
    for (int i = 0; i < 150; i++) send_random();
    write_base(ptmap_pkg::AddrW'({$urandom, $urandom}));
    for (int i = 0; i < 300; i++) send_random();
    write_base('0);
    for (int i = 0; i < 270; i++) send_random();
    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
